// ----- design/clcd_pkg.sv -----
package clcd_pkg;

  localparam int unsigned DEF_NUM_COLUMNS = 20;
  localparam int unsigned DEF_NUM_LINES   = 4;

  // item kinds carried on the input tuser
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_TEXT   = 2'd1;
  localparam logic [1:0] CMD_INIT   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // expander control nibbles: backlight, enable, register select
  localparam logic [3:0] CTL_CMD_EN = 4'hC;
  localparam logic [3:0] CTL_CMD    = 4'h8;
  localparam logic [3:0] CTL_DAT_EN = 4'hD;
  localparam logic [3:0] CTL_DAT    = 4'h9;

  localparam logic [7:0] SET_DDRAM  = 8'h80;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] LEAD_BYTE  = 8'hC3;
  localparam logic [6:0] LINE1_BASE = 7'h40;

  localparam int unsigned INIT_LEN = 9;

  typedef enum logic [2:0] {
    SRC_ADDR,
    SRC_SPACE,
    SRC_INIT,
    SRC_TEXT,
    SRC_MAP
  } src_e;

  typedef struct packed {
    logic load;       // latch the accepted item
    logic cnt_init;   // load the counter for the init sequence
    logic emit;       // push one frame into the output register
    src_e src;
    logic last;
    logic cnt_step;
  } clcd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_zero;
    logic is_lead;
    logic map_hit;
  } clcd_stat_t;

  function automatic logic [31:0] make_frame(logic [7:0] b, logic is_data);
    logic [3:0] en;
    logic [3:0] off;
    en  = is_data ? CTL_DAT_EN : CTL_CMD_EN;
    off = is_data ? CTL_DAT : CTL_CMD;
    return {b[7:4], en, b[7:4], off, b[3:0], en, b[3:0], off};
  endfunction

  // indexed by the remaining count, so the first command sits at the top
  function automatic logic [7:0] init_byte(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd8:    b = 8'h30;
      4'd7:    b = 8'h30;
      4'd6:    b = 8'h30;
      4'd5:    b = 8'h20;
      4'd4:    b = 8'h28;
      4'd3:    b = 8'h08;
      4'd2:    b = 8'h01;
      4'd1:    b = 8'h06;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

  // second byte of a C3 pair: {hit, display code}
  function automatic logic [8:0] map_umlaut(logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'hA4:   r = {1'b1, 8'hE1};
      8'hB6:   r = {1'b1, 8'hEF};
      8'hBC:   r = {1'b1, 8'hF5};
      8'h9F:   r = {1'b1, 8'hE2};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/clcd_ctrl.sv -----
module clcd_ctrl
  import clcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_ready_o,
  input  clcd_stat_t stat_i,
  output clcd_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CUR1 = 3'd1;
  localparam logic [2:0] ST_SPC  = 3'd2;
  localparam logic [2:0] ST_CUR2 = 3'd3;
  localparam logic [2:0] ST_INIT = 3'd4;
  localparam logic [2:0] ST_TEXT = 3'd5;

  logic [2:0] state_q, state_d;
  logic       lead_q, lead_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    lead_d         = lead_q;
    cmd_o          = '0;
    cmd_o.src      = SRC_ADDR;
    cmd_o.load     = accept;
    cmd_o.cnt_init = (in_kind_i == CMD_INIT);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            CMD_START: begin
              state_d = ST_CUR1;
              lead_d  = 1'b0;
            end
            CMD_TEXT: state_d = ST_TEXT;
            CMD_INIT: begin
              state_d = ST_INIT;
              lead_d  = 1'b0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CUR1: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_SPC;
        end
      end
      ST_SPC: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.src      = SRC_SPACE;
          cmd_o.cnt_step = 1'b1;
          if (stat_i.cnt_zero) begin
            state_d = ST_CUR2;
          end
        end
      end
      ST_CUR2: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_INIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.src      = SRC_INIT;
          cmd_o.cnt_step = 1'b1;
          cmd_o.last     = stat_i.cnt_zero;
          if (stat_i.cnt_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_TEXT: begin
        if (lead_q) begin
          // drop an unmapped follower, send a mapped one
          if (!stat_i.map_hit) begin
            lead_d  = 1'b0;
            state_d = ST_IDLE;
          end else if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.src  = SRC_MAP;
            cmd_o.last = 1'b1;
            lead_d     = 1'b0;
            state_d    = ST_IDLE;
          end
        end else if (stat_i.is_lead) begin
          lead_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_TEXT;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lead_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lead_q  <= lead_d;
    end
  end

endmodule

// ----- design/clcd_dp.sv -----
module clcd_dp
  import clcd_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = DEF_NUM_COLUMNS,
  parameter int unsigned NUM_LINES   = DEF_NUM_LINES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  line_i,
  input  logic [4:0]  column_i,
  input  logic [7:0]  char_i,
  input  clcd_cmd_t   cmd_i,
  output clcd_stat_t  stat_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_frame_o,
  output logic        out_last_o
);

  localparam int unsigned CNT_W = ($clog2(NUM_COLUMNS) > 4) ? $clog2(NUM_COLUMNS) : 4;
  localparam int unsigned COL_W = 6;

  logic [1:0]       line_c;
  logic [COL_W-1:0] col_c;
  logic [6:0]       base;
  logic [7:0]       addr;
  logic [7:0]       addr_q;
  logic [7:0]       char_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [8:0]       map_r;
  logic [7:0]       sel_byte;
  logic             sel_data;
  logic             valid_q;
  logic [31:0]      frame_q;
  logic             last_q;

  // clamp line and column, then form the set-cursor command
  always_comb begin
    line_c = ({1'b0, line_i} >= 3'(NUM_LINES)) ? 2'(NUM_LINES - 1) : line_i;
    col_c  = ({1'b0, column_i} >= COL_W'(NUM_COLUMNS)) ? COL_W'(NUM_COLUMNS - 1)
                                                       : {1'b0, column_i};
    unique case (line_c)
      2'd0:    base = 7'd0;
      2'd1:    base = LINE1_BASE;
      2'd2:    base = 7'(NUM_COLUMNS);
      default: base = 7'(LINE1_BASE + 7'(NUM_COLUMNS));
    endcase
    addr = SET_DDRAM | {1'b0, 7'(base + 7'(col_c))};
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = cmd_i.cnt_init ? CNT_W'(INIT_LEN - 1)
                             : CNT_W'(NUM_COLUMNS - 1) - CNT_W'(col_c);
    end else if (cmd_i.cnt_step) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (cmd_i.load) begin
      addr_q <= addr;
      char_q <= char_i;
    end
  end

  assign map_r = map_umlaut(char_q);

  always_comb begin
    case (cmd_i.src)
      SRC_ADDR: begin
        sel_byte = addr_q;
        sel_data = 1'b0;
      end
      SRC_SPACE: begin
        sel_byte = SPACE_CHAR;
        sel_data = 1'b1;
      end
      SRC_INIT: begin
        sel_byte = init_byte(cnt_q[3:0]);
        sel_data = 1'b0;
      end
      SRC_MAP: begin
        sel_byte = map_r[7:0];
        sel_data = 1'b1;
      end
      default: begin
        sel_byte = char_q;
        sel_data = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      frame_q <= make_frame(sel_byte, sel_data);
      last_q  <= cmd_i.last;
    end
  end

  assign stat_o.out_free = !valid_q || out_ready_i;
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.is_lead  = (char_q == LEAD_BYTE);
  assign stat_o.map_hit  = map_r[8];

  assign out_valid_o = valid_q;
  assign out_frame_o = frame_q;
  assign out_last_o  = last_q;

endmodule

// ----- design/char_lcd_i2c_text_writer_core.sv -----
// Character-LCD text writer: turns LCD operations into 32-bit frames for an
// I2C port expander driving an HD44780-type display in 4-bit mode.
// Input stream: tuser selects the operation (start write, text byte, init),
// tdata carries line, column and text byte. One item is taken at a time.
// Output stream: one word per LCD byte, first expander byte in bits 31..24;
// tlast marks the last word caused by an item.
// Work per item, from acceptance until the block takes the next item:
//   text byte: one word (a C3 lead byte or a dropped follower: no word)
//   start write: cursor, NUM_COLUMNS - column blanks (column clamped), cursor
//   init: nine commands
// The controller first takes up the item in its state register, then moves
// one word per cycle into the single output register while it is free; the
// first word is valid after the state register and then the output register.
// Reset clears the controller, the held lead byte and the output valid.
// A stalled receiver holds the output word and the controller waits; input
// tready stays low until the item's last word is in the output register.
module char_lcd_i2c_text_writer_core
  import clcd_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = DEF_NUM_COLUMNS,
  parameter int unsigned NUM_LINES   = DEF_NUM_LINES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // line[1:0], column[6:2], char_byte[14:7], zero[15]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // frame[31:0]
  output logic        m_axis_tlast
);

  clcd_cmd_t  cmd;
  clcd_stat_t stat;

  clcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  clcd_dp #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_LINES   (NUM_LINES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .line_i      (s_axis_tdata[1:0]),
    .column_i    (s_axis_tdata[6:2]),
    .char_i      (s_axis_tdata[14:7]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_frame_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- design/clcd_chk.sv -----
module clcd_chk
  import clcd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // any real command closes the input in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_UNUSED) |=> !s_axis_tready)
    else $error("input taken again too early");

  // each word is one byte sent as two nibbles with enable high then low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[31:28] == m_axis_tdata[23:20]) &&
      (m_axis_tdata[15:12] == m_axis_tdata[7:4]) &&
      (m_axis_tdata[27:24] == m_axis_tdata[11:8]) &&
      (m_axis_tdata[19:16] == m_axis_tdata[3:0]) &&
      m_axis_tdata[26] && !m_axis_tdata[18] && m_axis_tdata[27] &&
      (m_axis_tdata[24] == m_axis_tdata[16]))
    else $error("malformed expander word");

  // nothing is offered while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind char_lcd_i2c_text_writer_core clcd_chk u_clcd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- sim/char_lcd_i2c_text_writer_core_test.sv -----
`timescale 1ns / 1ps

module char_lcd_i2c_text_writer_core_test;
  import clcd_pkg::*;

  localparam int unsigned COLS = DEF_NUM_COLUMNS;
  localparam int unsigned LINES = DEF_NUM_LINES;
  localparam int unsigned RANDOM_ITEMS = 405;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // set-up commands in send order, first one in the top byte
  localparam logic [71:0] SETUP_BYTES = 72'h30_30_30_20_28_08_01_06_0C;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] line;
    logic [4:0] column;
    logic [7:0] ch;
  } lcd_item_t;

  typedef struct packed {
    logic [31:0] frame;
    logic        last;
  } lcd_word_t;

  class lcd_frame_board;
    lcd_word_t pending_frames[$];
    logic      lead_held;
    int        mismatches;
    int        words_checked;
    int        starts;
    int        texts;
    int        inits;
    int        ignored;

    function new();
      lead_held = 1'b0;
      mismatches = 0;
      words_checked = 0;
      starts = 0;
      texts = 0;
      inits = 0;
      ignored = 0;
    endfunction

    // four expander bytes: high nibble with E, without E, then the low nibble
    function logic [31:0] expander_word(logic [7:0] b, logic is_data);
      logic [3:0] strobe;
      logic [3:0] idle;
      logic [7:0] hi_e;
      logic [7:0] hi_n;
      logic [7:0] lo_e;
      logic [7:0] lo_n;
      strobe = is_data ? CTL_DAT_EN : CTL_CMD_EN;
      idle   = is_data ? CTL_DAT : CTL_CMD;
      hi_e = {b[7:4], strobe};
      hi_n = {b[7:4], idle};
      lo_e = {b[3:0], strobe};
      lo_n = {b[3:0], idle};
      return {hi_e, hi_n, lo_e, lo_n};
    endfunction

    function logic [7:0] cursor_command(logic [1:0] line, logic [4:0] column);
      int row;
      int col;
      int base;
      int sum;
      row = (line >= LINES) ? LINES - 1 : line;
      col = (column >= COLS) ? COLS - 1 : column;
      case (row)
        0:       base = 0;
        1:       base = LINE1_BASE;
        2:       base = COLS;
        default: base = LINE1_BASE + COLS;
      endcase
      sum = base + col;
      return SET_DDRAM | {1'b0, sum[6:0]};
    endfunction

    function void push_word(logic [7:0] b, logic is_data, logic last);
      lcd_word_t w;
      w.frame = expander_word(b, is_data);
      w.last  = last;
      pending_frames.push_back(w);
    endfunction

    function void note_item(lcd_item_t it);
      logic [7:0] addr;
      int first_col;
      case (it.cmd)
        CMD_START: begin
          starts++;
          lead_held = 1'b0;
          addr = cursor_command(it.line, it.column);
          first_col = (it.column >= COLS) ? COLS - 1 : it.column;
          push_word(addr, 1'b0, 1'b0);
          for (int c = first_col; c < COLS; c++) push_word(SPACE_CHAR, 1'b1, 1'b0);
          push_word(addr, 1'b0, 1'b1);
        end
        CMD_TEXT: begin
          texts++;
          if (lead_held) begin
            lead_held = 1'b0;
            // map the umlaut pairs, drop any other follower
            case (it.ch)
              8'hA4:   push_word(8'hE1, 1'b1, 1'b1);
              8'hB6:   push_word(8'hEF, 1'b1, 1'b1);
              8'hBC:   push_word(8'hF5, 1'b1, 1'b1);
              8'h9F:   push_word(8'hE2, 1'b1, 1'b1);
              default: ;
            endcase
          end else if (it.ch == LEAD_BYTE) begin
            lead_held = 1'b1;
          end else begin
            push_word(it.ch, 1'b1, 1'b1);
          end
        end
        CMD_INIT: begin
          inits++;
          lead_held = 1'b0;
          for (int i = 0; i < 9; i++) push_word(SETUP_BYTES[71 - 8 * i -: 8], 1'b0, i == 8);
        end
        default: ignored++;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_word(logic [31:0] frame, logic last);
      lcd_word_t want;
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("word %h last %b with nothing pending", frame, last));
      end else begin
        want = pending_frames.pop_front();
        words_checked++;
        if (frame !== want.frame)
          report_mismatch($sformatf("frame %h, expected %h", frame, want.frame));
        if (last !== want.last)
          report_mismatch($sformatf("tlast %b, expected %b (frame %h)", last, want.last,
                                    want.frame));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  lcd_frame_board board;
  logic           no_idle;
  int             idle_cycles;

  char_lcd_i2c_text_writer_core #(
    .NUM_COLUMNS(COLS),
    .NUM_LINES  (LINES)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // observe both streams at the edge, before the block updates
  always @(posedge clk_i) begin
    lcd_item_t seen;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen.cmd    = s_axis_tuser;
        seen.line   = s_axis_tdata[1:0];
        seen.column = s_axis_tdata[6:2];
        seen.ch     = s_axis_tdata[14:7];
        board.note_item(seen);
      end
      if (m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: stall a random number of cycles before each word
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic drive_item(logic [1:0] cmd, logic [1:0] line, logic [4:0] column,
                            logic [7:0] ch);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, ch, column, line};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // unused fields carry random junk so every bit moves
  task automatic send_text(logic [7:0] ch);
    drive_item(CMD_TEXT, 2'($urandom), 5'($urandom), ch);
  endtask

  task automatic send_start(logic [1:0] line, logic [4:0] column);
    drive_item(CMD_START, line, column, 8'($urandom));
  endtask

  task automatic send_op(logic [1:0] cmd);
    drive_item(cmd, 2'($urandom), 5'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] pick_follower();
    case ($urandom_range(0, 4))
      0:       return 8'hA4;
      1:       return 8'hB6;
      2:       return 8'hBC;
      3:       return 8'h9F;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int pick;
    int sent;
    board = new();
    no_idle = 1'b0;
    idle_cycles = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser <= CMD_UNUSED;
    s_axis_tdata <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every operation, the umlaut pairs and their breaks
    send_op(CMD_INIT);
    send_start(2'd0, 5'd0);
    send_start(2'd3, 5'd19);
    send_start(2'd1, 5'd31);
    send_start(2'd2, 5'd20);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(LEAD_BYTE); send_text(8'hA4);
    send_text(LEAD_BYTE); send_text(8'hB6);
    send_text(LEAD_BYTE); send_text(8'hBC);
    send_text(LEAD_BYTE); send_text(8'h9F);
    send_text(LEAD_BYTE); send_text(8'h41);
    send_text(LEAD_BYTE); send_text(LEAD_BYTE); send_text(8'h41);
    send_text(LEAD_BYTE); send_start(2'd2, 5'd18); send_text(8'hA4);
    send_text(LEAD_BYTE); send_op(CMD_UNUSED); send_text(8'hA4);
    send_text(LEAD_BYTE); send_op(CMD_INIT); send_text(8'hB6);

    // random: mostly text with umlaut pairs (some followers unmapped), a few cursor moves, init runs and ignored items
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ((sent / 32) % 4) == 3;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_start(2'($urandom),
                   ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(12, 31)));
        sent++;
      end else if (pick < 10) begin
        send_op(CMD_INIT);
        sent++;
      end else if (pick < 12) begin
        send_op(CMD_UNUSED);
      end else if (pick < 32) begin
        send_text(LEAD_BYTE);
        send_text(pick_follower());
        sent += 2;
      end else if (pick < 35) begin
        // break a pair with a cursor move
        send_text(LEAD_BYTE);
        send_start(2'($urandom), 5'($urandom_range(15, 31)));
        sent += 2;
      end else begin
        send_text(8'($urandom));
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1'b0;

    while (board.pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d start writes, %0d text bytes, %0d init runs, %0d ignored items",
             board.starts, board.texts, board.inits, board.ignored);
    $display("Checked %0d output words, %0d mismatches", board.words_checked,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
